// ===== hw/rtl/opt_pkg.sv =====
// Shared types and constants of the output pin timer controller.
// Used by the channel interfaces, controller, datapath and checker.
`timescale 1ns / 1ps
`default_nettype none

package opt_pkg;

	localparam int TIMER_SLOTS_DEF = 8;
	localparam int EXPANDERS_DEF   = 8;

	localparam int ADDR_W    = 3;
	localparam int PIN_W     = 4;
	localparam int CTX_W     = 8;
	localparam int WORD_W    = 16;
	localparam int HALF_W    = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;
	localparam int ADDR_CNT  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_HALFMIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK      = 4'd1;

	localparam logic [15:0] TICKS_RESET   = 16'd30000;
	localparam logic [7:0]  PRESENT_RESET = 8'hFF;

	typedef enum logic [1:0] {
		CMD_TICK        = 2'd0,
		CMD_TOGGLE      = 2'd1,
		CMD_TIMER_RESET = 2'd2,
		CMD_ALL_OFF     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WALK,
		ST_SEARCH,
		ST_APPLY,
		ST_FLUSH
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_PRESCALE,
		OP_WALK_SLOT,
		OP_TOGGLE,
		OP_SEARCH_STEP,
		OP_APPLY,
		OP_ALL_OFF,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   in_ready;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		cmd_t cmd;
		logic roll;
		logic hit;
		logic idx_last;
		logic pend_any;
		logic pend_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/opt_if.sv =====
// Valid/ready channels of the output pin timer controller: command input,
// expander write output and register write port. Widths from opt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface opt_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 cmd;
	logic [opt_pkg::ADDR_W-1:0] exp_address;
	logic [opt_pkg::PIN_W-1:0]  pin_index;
	logic [opt_pkg::CTX_W-1:0]  context_req;

	modport source(output valid, cmd, exp_address, pin_index, context_req, input ready);
	modport sink(input valid, cmd, exp_address, pin_index, context_req, output ready);
endinterface

interface opt_out_if;
	logic                       valid;
	logic                       ready;
	logic [opt_pkg::ADDR_W-1:0] write_address;
	logic [opt_pkg::WORD_W-1:0] write_pins;
	logic                       last;

	modport source(output valid, write_address, write_pins, last, input ready);
	modport sink(input valid, write_address, write_pins, last, output ready);
endinterface

interface opt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [opt_pkg::CFG_IDX_W-1:0] index;
	logic [opt_pkg::CFG_DAT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/output_pin_timer_controller_top.sv =====
// Steps: a tick below the prescale limit is captured and decoded; a half-minute tick also
// walks every timer slot, then writes each changed expander; a toggle writes its expander;
// a timer reset searches the slots, applies, then writes any changed word; all off writes
// each present expander. Output stalls hold writes; a new command waits for the last.
// Reset: outputs and timers cleared, prescaler zero, registers at 30000 and 0xFF.
// Top level of the output pin timer controller; depends on opt_pkg, opt_if,
// opt_ctrl and opt_dp.
`timescale 1ns / 1ps
`default_nettype none

module output_pin_timer_controller_top #(
	parameter int TIMER_SLOTS = opt_pkg::TIMER_SLOTS_DEF,
	parameter int EXPANDERS   = opt_pkg::EXPANDERS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	opt_in_if.sink    in_ch,
	opt_out_if.source out_ch,
	opt_cfg_if.sink   cfg_ch
);

	opt_pkg::ctrl_t ctrl;
	opt_pkg::stat_t stat;

	opt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	opt_dp #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.EXPANDERS   (EXPANDERS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch),
		.ctrl   (ctrl),
		.stat   (stat)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/opt_ctrl.sv =====
// Sequencer of the output pin timer controller: steps the datapath through
// one command at a time. Depends on opt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module opt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire opt_pkg::stat_t stat,
	output opt_pkg::ctrl_t      ctrl
);

	opt_pkg::state_t state_q;
	opt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctrl.op       = opt_pkg::OP_NOP;
		ctrl.in_ready = 1'b0;
		unique case (state_q)
			opt_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (stat.in_valid) begin
					ctrl.op = opt_pkg::OP_CAPTURE;
					state_d = opt_pkg::ST_DECODE;
				end
			end
			opt_pkg::ST_DECODE: begin
				unique case (stat.cmd)
					opt_pkg::CMD_TICK: begin
						ctrl.op = opt_pkg::OP_PRESCALE;
						state_d = stat.roll ? opt_pkg::ST_WALK : opt_pkg::ST_IDLE;
					end
					opt_pkg::CMD_TOGGLE: begin
						ctrl.op = opt_pkg::OP_TOGGLE;
						state_d = opt_pkg::ST_FLUSH;
					end
					opt_pkg::CMD_TIMER_RESET: begin
						ctrl.op = opt_pkg::OP_SEARCH_STEP;
						state_d = (stat.hit || stat.idx_last) ? opt_pkg::ST_APPLY
							: opt_pkg::ST_SEARCH;
					end
					opt_pkg::CMD_ALL_OFF: begin
						ctrl.op = opt_pkg::OP_ALL_OFF;
						state_d = opt_pkg::ST_FLUSH;
					end
					default: state_d = opt_pkg::ST_IDLE;
				endcase
			end
			opt_pkg::ST_WALK: begin
				ctrl.op = opt_pkg::OP_WALK_SLOT;
				if (stat.idx_last) begin
					state_d = opt_pkg::ST_FLUSH;
				end
			end
			opt_pkg::ST_SEARCH: begin
				ctrl.op = opt_pkg::OP_SEARCH_STEP;
				if (stat.hit || stat.idx_last) begin
					state_d = opt_pkg::ST_APPLY;
				end
			end
			opt_pkg::ST_APPLY: begin
				ctrl.op = opt_pkg::OP_APPLY;
				state_d = opt_pkg::ST_FLUSH;
			end
			opt_pkg::ST_FLUSH: begin
				// drain pending writes lowest address first
				if (!stat.pend_any) begin
					state_d = opt_pkg::ST_IDLE;
				end else if (stat.out_free) begin
					ctrl.op = opt_pkg::OP_EMIT;
					if (stat.pend_last) begin
						state_d = opt_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = opt_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/opt_dp.sv =====
// Datapath of the output pin timer controller: registers, prescaler, timer
// slot table, expander output words and output register. Depends on opt_pkg, opt_if.
`timescale 1ns / 1ps
`default_nettype none

module opt_dp #(
	parameter int TIMER_SLOTS = opt_pkg::TIMER_SLOTS_DEF,
	parameter int EXPANDERS   = opt_pkg::EXPANDERS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	opt_in_if.sink              in_ch,
	opt_out_if.source           out_ch,
	opt_cfg_if.sink             cfg_ch,
	input  wire opt_pkg::ctrl_t ctrl,
	output opt_pkg::stat_t      stat
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int EXP_W = (EXPANDERS > 1) ? $clog2(EXPANDERS) : 1;

	// captured command
	opt_pkg::cmd_t                cmd_q;
	logic [opt_pkg::ADDR_W-1:0]   addr_q;
	logic [opt_pkg::PIN_W-1:0]    pin_q;
	logic [opt_pkg::CTX_W-1:0]    ctx_q;

	logic                         zero_q;
	logic [opt_pkg::ADDR_CNT-1:0] pend_q;
	logic [IDX_W-1:0]             idx_q;

	logic [15:0]                  tpm_q;
	logic [7:0]                   mask_q;
	logic [15:0]                  pre_q;

	logic [opt_pkg::ADDR_W-1:0]   s_addr_q [TIMER_SLOTS];
	logic [opt_pkg::PIN_W-1:0]    s_pin_q  [TIMER_SLOTS];
	logic [opt_pkg::HALF_W-1:0]   s_half_q [TIMER_SLOTS];
	logic                         s_res_q  [TIMER_SLOTS];
	logic                         s_cnt_q  [TIMER_SLOTS];

	logic [opt_pkg::WORD_W-1:0]   bits_q [EXPANDERS];

	logic                         out_valid_q;
	logic [opt_pkg::ADDR_W-1:0]   out_addr_q;
	logic [opt_pkg::WORD_W-1:0]   out_pins_q;
	logic                         out_last_q;

	logic [opt_pkg::ADDR_CNT-1:0] present;
	logic [opt_pkg::ADDR_W-1:0]   c_addr;
	logic [opt_pkg::PIN_W-1:0]    c_pin;
	logic [opt_pkg::HALF_W-1:0]   c_half;
	logic                         c_res;
	logic                         c_cnt;
	logic [opt_pkg::HALF_W-1:0]   half_dec;
	logic                         hit;
	logic                         idx_last;
	logic [IDX_W-1:0]             idx_next;
	logic [opt_pkg::ADDR_W-1:0]   low_addr;
	logic [opt_pkg::ADDR_CNT-1:0] pend_rest;
	logic [opt_pkg::ADDR_W-1:0]   rd_addr;
	logic [EXP_W-1:0]             rd_idx;
	logic                         rd_present;
	logic [opt_pkg::WORD_W-1:0]   rd_word;
	logic [opt_pkg::PIN_W-1:0]    pin_sel;
	logic [opt_pkg::WORD_W-1:0]   pmask;
	logic                         word_we;
	logic [opt_pkg::WORD_W-1:0]   word_wd;
	logic                         roll;
	logic                         out_free;
	logic                         accept;

	assign accept       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = ctrl.in_ready;
	assign cfg_ch.ready = 1'b1;

	always_comb begin
		for (int i = 0; i < opt_pkg::ADDR_CNT; i++) begin
			present[i] = (i < EXPANDERS) && mask_q[i];
		end
	end

	assign c_addr   = s_addr_q[idx_q];
	assign c_pin    = s_pin_q[idx_q];
	assign c_half   = s_half_q[idx_q];
	assign c_res    = s_res_q[idx_q];
	assign c_cnt    = s_cnt_q[idx_q];
	assign half_dec = c_half - 8'd1;
	assign hit      = ((c_addr == addr_q) && (c_pin == pin_q)) || !c_cnt;
	assign idx_last = (idx_q == IDX_W'(TIMER_SLOTS - 1));
	assign idx_next = idx_last ? '0 : idx_q + IDX_W'(1);

	always_comb begin
		low_addr = '0;
		for (int i = opt_pkg::ADDR_CNT - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				low_addr = opt_pkg::ADDR_W'(i);
			end
		end
	end

	assign pend_rest = pend_q & (pend_q - 8'd1);

	// one read and one write port on the expander words
	always_comb begin
		rd_addr = addr_q;
		pin_sel = pin_q;
		unique case (ctrl.op)
			opt_pkg::OP_WALK_SLOT: begin
				rd_addr = c_addr;
				pin_sel = c_pin;
			end
			opt_pkg::OP_APPLY: begin
				if (c_cnt) begin
					rd_addr = c_addr;
					pin_sel = c_pin;
				end
			end
			opt_pkg::OP_EMIT: rd_addr = low_addr;
			default: ;
		endcase
	end

	assign rd_present = present[rd_addr];
	assign rd_idx     = rd_present ? rd_addr[EXP_W-1:0] : '0;
	assign rd_word    = bits_q[rd_idx];
	assign pmask      = opt_pkg::WORD_W'(1) << pin_sel;

	always_comb begin
		word_we = 1'b0;
		word_wd = rd_word;
		unique case (ctrl.op)
			opt_pkg::OP_WALK_SLOT: begin
				word_we = c_cnt && (half_dec == '0) && rd_present;
				word_wd = rd_word & ~pmask;
			end
			opt_pkg::OP_TOGGLE: begin
				word_we = rd_present;
				word_wd = rd_word ^ pmask;
			end
			opt_pkg::OP_APPLY: begin
				if (c_cnt) begin
					word_we = !c_res && rd_present;
					word_wd = rd_word & ~pmask;
				end else begin
					word_we = rd_present;
					word_wd = rd_word | pmask;
				end
			end
			opt_pkg::OP_EMIT: begin
				word_we = zero_q;
				word_wd = '0;
			end
			default: ;
		endcase
	end

	assign roll     = ({1'b0, pre_q} + 17'd1) >= {1'b0, tpm_q};
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q      <= 1'b0;
			pend_q      <= '0;
			idx_q       <= '0;
			tpm_q       <= opt_pkg::TICKS_RESET;
			mask_q      <= opt_pkg::PRESENT_RESET;
			pre_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				s_cnt_q[i] <= 1'b0;
			end
			for (int i = 0; i < EXPANDERS; i++) begin
				bits_q[i] <= '0;
			end
		end else begin
			if (cfg_ch.valid) begin
				if (cfg_ch.index == opt_pkg::REG_TICKS_PER_HALFMIN) begin
					tpm_q <= cfg_ch.data;
				end else if (cfg_ch.index == opt_pkg::REG_PRESENT_MASK) begin
					mask_q <= cfg_ch.data[7:0];
				end
			end

			if (word_we) begin
				bits_q[rd_idx] <= word_wd;
			end

			if (ctrl.op == opt_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (ctrl.op)
				opt_pkg::OP_CAPTURE: begin
					zero_q <= 1'b0;
					pend_q <= '0;
					idx_q  <= '0;
				end
				opt_pkg::OP_PRESCALE: begin
					pre_q <= roll ? '0 : pre_q + 16'd1;
				end
				opt_pkg::OP_WALK_SLOT: begin
					if (c_cnt && (half_dec == '0)) begin
						s_cnt_q[idx_q] <= 1'b0;
					end
					if (word_we) begin
						pend_q[rd_addr] <= 1'b1;
					end
					idx_q <= idx_next;
				end
				opt_pkg::OP_TOGGLE: begin
					if (word_we) begin
						pend_q[rd_addr] <= 1'b1;
					end
				end
				opt_pkg::OP_SEARCH_STEP: begin
					// hold on a hit, fall back to slot 0 when none matches
					if (!hit) begin
						idx_q <= idx_next;
					end
				end
				opt_pkg::OP_APPLY: begin
					if (c_cnt && c_res) begin
						pre_q <= '0;
					end else if (c_cnt) begin
						s_cnt_q[idx_q] <= 1'b0;
					end else begin
						s_cnt_q[idx_q] <= 1'b1;
					end
					if (word_we) begin
						pend_q[rd_addr] <= 1'b1;
					end
				end
				opt_pkg::OP_ALL_OFF: begin
					zero_q <= 1'b1;
					pend_q <= present;
				end
				opt_pkg::OP_EMIT: begin
					pend_q <= pend_rest;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= opt_pkg::cmd_t'(in_ch.cmd);
			addr_q <= in_ch.exp_address;
			pin_q  <= in_ch.pin_index;
			ctx_q  <= in_ch.context_req;
		end
		if (ctrl.op == opt_pkg::OP_WALK_SLOT && c_cnt) begin
			s_half_q[idx_q] <= half_dec;
		end
		if (ctrl.op == opt_pkg::OP_APPLY) begin
			if (c_cnt && c_res) begin
				s_half_q[idx_q] <= {1'b0, ctx_q[opt_pkg::CTX_W-1:1]};
			end else if (!c_cnt) begin
				s_addr_q[idx_q] <= addr_q;
				s_pin_q[idx_q]  <= pin_q;
				s_half_q[idx_q] <= {1'b0, ctx_q[opt_pkg::CTX_W-1:1]};
				s_res_q[idx_q]  <= ctx_q[0];
			end
		end
		if (ctrl.op == opt_pkg::OP_EMIT) begin
			out_addr_q <= low_addr;
			out_pins_q <= zero_q ? '0 : rd_word;
			out_last_q <= (pend_rest == '0);
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.write_address = out_addr_q;
	assign out_ch.write_pins    = out_pins_q;
	assign out_ch.last          = out_last_q;

	assign stat.in_valid  = in_ch.valid;
	assign stat.cmd       = cmd_q;
	assign stat.roll      = roll;
	assign stat.hit       = hit;
	assign stat.idx_last  = idx_last;
	assign stat.pend_any  = |pend_q;
	assign stat.pend_last = (pend_rest == '0);
	assign stat.out_free  = out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/opt_checker.sv =====
// Port-level checks of the output pin timer controller, bound to the top
// level. Depends on opt_pkg widths.
`timescale 1ns / 1ps
`default_nettype none

module opt_checker #(
	parameter int EXPANDERS = opt_pkg::EXPANDERS_DEF
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [opt_pkg::ADDR_W-1:0] write_address,
	input wire logic [opt_pkg::WORD_W-1:0] write_pins,
	input wire logic                       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(write_address) && $stable(write_pins)
			&& $stable(last))
		else $error("output beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while previous one in progress");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(write_address) < EXPANDERS))
		else $error("write to expander address beyond configured count");

endmodule

bind output_pin_timer_controller_top opt_checker #(
	.EXPANDERS (EXPANDERS)
) u_opt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.write_address (out_ch.write_address),
	.write_pins    (out_ch.write_pins),
	.last          (out_ch.last)
);

`default_nettype wire
